FILE: rtl/core/mavb_pkg.sv
// Shared types and constants for the moving average bank.
// Used by all rtl/core modules but mavb_tap_cell; no dependencies of its own.
package mavb_pkg;

    localparam int unsigned PRICE_WINDOWS  = 8;
    localparam int unsigned VOLUME_WINDOWS = 3;
    localparam int unsigned PRICE_DEPTH    = 200;
    localparam int unsigned VOLUME_DEPTH   = 60;
    localparam int unsigned COUNT_W        = 8;
    localparam int unsigned AVG_W          = 32;
    localparam int unsigned FIELD_W        = 32;

    localparam logic [COUNT_W-1:0] COUNT_CAP = 8'd201;

    localparam int unsigned PRICE_LEN [PRICE_WINDOWS] = '{10, 20, 30, 50, 60, 100, 120, 200};
    localparam int unsigned VOLUME_LEN [VOLUME_WINDOWS] = '{10, 20, 60};

    typedef struct packed {
        logic [FIELD_W-1:0] close_price;
        logic [FIELD_W-1:0] bar_volume;
        logic               series_start;
    } mavb_in_t;

    typedef struct packed {
        logic [AVG_W-1:0] price_avg_10;
        logic [AVG_W-1:0] price_avg_20;
        logic [AVG_W-1:0] price_avg_30;
        logic [AVG_W-1:0] price_avg_50;
        logic [AVG_W-1:0] price_avg_60;
        logic [AVG_W-1:0] price_avg_100;
        logic [AVG_W-1:0] price_avg_120;
        logic [AVG_W-1:0] price_avg_200;
        logic [AVG_W-1:0] volume_avg_10;
        logic [AVG_W-1:0] volume_avg_20;
        logic [AVG_W-1:0] volume_avg_60;
        logic [10:0]      ready_mask;
    } mavb_out_t;

    // Window update control: transfer strobe and bars of the series before this one
    typedef struct packed {
        logic               take;
        logic [COUNT_W-1:0] prior;
    } mavb_ctrl_t;

    // Load enables of the divider stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } mavb_pipe_en_t;

endpackage

FILE: rtl/core/moving_average_bank.sv
// A transfer reaches m_valid via sum, product, partial sum and output registers.
// Throughput: one bar per cycle absent m_ready stalls; set by each running sum.
// Reset (aresetn, synchronous, active low) clears the bar count and stage valids;
// delay line and sums go uncleared; a series start resets sums and skips old taps.
// Uses mavb_pkg, mavb_tap_cell, mavb_window and mavb_const_div.
module moving_average_bank #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mavb_pkg::mavb_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mavb_pkg::mavb_out_t m_data
);

    localparam int PW = mavb_pkg::PRICE_WINDOWS;
    localparam int VW = mavb_pkg::VOLUME_WINDOWS;
    localparam int PD = mavb_pkg::PRICE_DEPTH;
    localparam int VD = mavb_pkg::VOLUME_DEPTH;

    logic [mavb_pkg::COUNT_W-1:0] bars_seen_reg;
    logic [mavb_pkg::COUNT_W-1:0] bars_seen_next;
    logic [mavb_pkg::COUNT_W-1:0] prior;
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic take;

    logic [SAMPLE_WIDTH+mavb_pkg::FIELD_W-1:0] price_ext;
    logic [SAMPLE_WIDTH+mavb_pkg::FIELD_W-1:0] volume_ext;
    logic [SAMPLE_WIDTH-1:0] price_in;
    logic [SAMPLE_WIDTH-1:0] volume_in;
    logic [SAMPLE_WIDTH-1:0] price_line  [PD];
    logic [SAMPLE_WIDTH-1:0] volume_line [VD];

    mavb_pkg::mavb_ctrl_t    ctrl;
    mavb_pkg::mavb_pipe_en_t pipe_en;

    logic [mavb_pkg::AVG_W-1:0] price_avg  [PW];
    logic [mavb_pkg::AVG_W-1:0] volume_avg [VW];
    logic [PW-1:0]              price_full;
    logic [VW-1:0]              volume_full;

    // Stages: sums (v0), partial products (v1), partial sums (v2), output (v3)
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = !v0_reg || rdy1;
    assign take    = s_valid && s_ready;
    assign m_valid = v3_reg;

    assign prior = s_data.series_start ? '0 : bars_seen_reg;
    assign bars_seen_next = (prior < mavb_pkg::COUNT_CAP) ? prior + 1'b1 : mavb_pkg::COUNT_CAP;

    assign ctrl.take     = take;
    assign ctrl.prior    = prior;
    assign pipe_en.ld1   = rdy1;
    assign pipe_en.ld2   = rdy2;
    assign pipe_en.ld3   = rdy3;

    assign price_ext  = {{SAMPLE_WIDTH{1'b0}}, s_data.close_price};
    assign volume_ext = {{SAMPLE_WIDTH{1'b0}}, s_data.bar_volume};
    assign price_in   = price_ext[SAMPLE_WIDTH-1:0];
    assign volume_in  = volume_ext[SAMPLE_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bars_seen_reg <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end else begin
            if (take) begin
                bars_seen_reg <= bars_seen_next;
            end
            v0_reg <= take || (v0_reg && !rdy1);
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Delay lines: cell k holds the sample k+1 bars back
    for (genvar k = 0; k < PD; k++) begin : g_price_line
        mavb_tap_cell #(.WIDTH(SAMPLE_WIDTH)) u_cell (
            .aclk (aclk),
            .en   (take),
            .d    ((k == 0) ? price_in : price_line[(k == 0) ? 0 : k - 1]),
            .q    (price_line[k])
        );
    end

    for (genvar k = 0; k < VD; k++) begin : g_volume_line
        mavb_tap_cell #(.WIDTH(SAMPLE_WIDTH)) u_cell (
            .aclk (aclk),
            .en   (take),
            .d    ((k == 0) ? volume_in : volume_line[(k == 0) ? 0 : k - 1]),
            .q    (volume_line[k])
        );
    end

    for (genvar g = 0; g < PW; g++) begin : g_price_win
        localparam int W = mavb_pkg::PRICE_LEN[g];
        localparam int N = SAMPLE_WIDTH + $clog2(W);
        logic [N-1:0] sum;
        logic         full;

        mavb_window #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .WINDOW(W)) u_win (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .sample (price_in),
            .tap    (price_line[W-1]),
            .sum    (sum),
            .full   (full)
        );

        mavb_const_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .WINDOW(W)) u_div (
            .aclk     (aclk),
            .en       (pipe_en),
            .sum      (sum),
            .full     (full),
            .avg      (price_avg[g]),
            .full_out (price_full[g])
        );
    end

    for (genvar g = 0; g < VW; g++) begin : g_volume_win
        localparam int W = mavb_pkg::VOLUME_LEN[g];
        localparam int N = SAMPLE_WIDTH + $clog2(W);
        logic [N-1:0] sum;
        logic         full;

        mavb_window #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .WINDOW(W)) u_win (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .sample (volume_in),
            .tap    (volume_line[W-1]),
            .sum    (sum),
            .full   (full)
        );

        mavb_const_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .WINDOW(W)) u_div (
            .aclk     (aclk),
            .en       (pipe_en),
            .sum      (sum),
            .full     (full),
            .avg      (volume_avg[g]),
            .full_out (volume_full[g])
        );
    end

    assign m_data.price_avg_10  = price_avg[0];
    assign m_data.price_avg_20  = price_avg[1];
    assign m_data.price_avg_30  = price_avg[2];
    assign m_data.price_avg_50  = price_avg[3];
    assign m_data.price_avg_60  = price_avg[4];
    assign m_data.price_avg_100 = price_avg[5];
    assign m_data.price_avg_120 = price_avg[6];
    assign m_data.price_avg_200 = price_avg[7];
    assign m_data.volume_avg_10 = volume_avg[0];
    assign m_data.volume_avg_20 = volume_avg[1];
    assign m_data.volume_avg_60 = volume_avg[2];
    assign m_data.ready_mask    = {volume_full, price_full};

    // A new series always counts its first bar as one
    a_start_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_data.series_start) |=> (bars_seen_reg == 8'd1))
        else $error("bar count not restarted by series start");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !s_data.series_start && (bars_seen_reg < mavb_pkg::COUNT_CAP))
        |=> (bars_seen_reg == mavb_pkg::COUNT_W'($past(bars_seen_reg) + 1)))
        else $error("bar count did not advance on transfer");

    // Longer windows fill only after shorter ones
    a_mask_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.ready_mask[7] || (&m_data.ready_mask[6:0]))
                 && (!m_data.ready_mask[10] || (&m_data.ready_mask[9:8])))
        else $error("ready mask out of window order");

    a_unready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ready_mask[0]) |-> (m_data.price_avg_10 == '0))
        else $error("average shown before window filled");

endmodule

FILE: rtl/core/mavb_tap_cell.sv
// One cell of a sample delay line: holds one sample and passes it on.
// Depends on nothing.
module mavb_tap_cell #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/mavb_window.sv
// Running sum of one moving window, updated once per transfer.
// Uses mavb_pkg.
module mavb_window #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int WINDOW       = 10
) (
    input  logic                                        aclk,
    input  mavb_pkg::mavb_ctrl_t                        ctrl,
    input  logic [SAMPLE_WIDTH-1:0]                     sample,
    input  logic [SAMPLE_WIDTH-1:0]                     tap,
    output logic [SAMPLE_WIDTH+$clog2(WINDOW)-1:0]      sum,
    output logic                                        full
);

    localparam int N = SAMPLE_WIDTH + $clog2(WINDOW);
    localparam logic [mavb_pkg::COUNT_W-1:0] WIN    = mavb_pkg::COUNT_W'(WINDOW);
    localparam logic [mavb_pkg::COUNT_W-1:0] WIN_M1 = mavb_pkg::COUNT_W'(WINDOW - 1);

    logic [N-1:0] sum_reg;
    logic [N-1:0] sum_next;
    logic         full_reg;
    logic [N-1:0] base;
    logic [N-1:0] leaving;

    // A new series (or the first bar after reset) restarts the sum.
    assign base     = (ctrl.prior == '0) ? '0 : sum_reg;
    assign leaving  = (ctrl.prior >= WIN) ? N'(tap) : '0;
    assign sum_next = base + N'(sample) - leaving;

    always_ff @(posedge aclk) begin
        if (ctrl.take) begin
            sum_reg  <= sum_next;
            full_reg <= (ctrl.prior >= WIN_M1);
        end
    end

    assign sum  = sum_reg;
    assign full = full_reg;

endmodule

FILE: rtl/core/mavb_const_div.sv
// Three-stage divide of a window sum by its constant length.
// Reciprocal multiply cut into four partial products; uses mavb_pkg.
module mavb_const_div #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int WINDOW       = 10
) (
    input  logic                                   aclk,
    input  mavb_pkg::mavb_pipe_en_t                en,
    input  logic [SAMPLE_WIDTH+$clog2(WINDOW)-1:0] sum,
    input  logic                                   full,
    output logic [mavb_pkg::AVG_W-1:0]             avg,
    output logic                                   full_out
);

    localparam int N = SAMPLE_WIDTH + $clog2(WINDOW);
    localparam int L = $clog2(WINDOW);
    localparam int S = N + L;
    localparam int P = 2 * N + 1;
    localparam int H = (N + 2) / 2;

    // ceil(2^S / WINDOW) is exact for every dividend below 2^N
    localparam logic [S:0] ONE_S  = {1'b1, {S{1'b0}}};
    localparam logic [S:0] M_FULL = (ONE_S + (S+1)'(WINDOW - 1)) / (S+1)'(WINDOW);
    localparam logic [N:0] M      = M_FULL[N:0];

    logic [2*H-1:0]       p_ll_reg;
    logic [N:0]           p_lh_reg;
    logic [N-1:0]         p_hl_reg;
    logic [2*N-2*H:0]     p_hh_reg;
    logic                 full1_reg;
    logic [P-1:0]         lo_reg;
    logic [P-1:0]         hi_reg;
    logic                 full2_reg;
    logic [P-1:0]         prod;
    logic [SAMPLE_WIDTH+mavb_pkg::AVG_W-1:0] q_ext;
    logic [mavb_pkg::AVG_W-1:0] avg_reg;
    logic [mavb_pkg::AVG_W-1:0] avg_next;
    logic                 full3_reg;

    assign prod     = lo_reg + (hi_reg << H);
    assign q_ext    = {{mavb_pkg::AVG_W{1'b0}}, prod[S+SAMPLE_WIDTH-1:S]};
    assign avg_next = full2_reg ? q_ext[mavb_pkg::AVG_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (en.ld1) begin
            p_ll_reg  <= sum[H-1:0] * M[H-1:0];
            p_lh_reg  <= sum[H-1:0] * M[N:H];
            p_hl_reg  <= sum[N-1:H] * M[H-1:0];
            p_hh_reg  <= sum[N-1:H] * M[N:H];
            full1_reg <= full;
        end
        if (en.ld2) begin
            lo_reg    <= P'(p_ll_reg) + (P'(p_lh_reg) << H);
            hi_reg    <= P'(p_hl_reg) + (P'(p_hh_reg) << H);
            full2_reg <= full1_reg;
        end
        if (en.ld3) begin
            avg_reg   <= avg_next;
            full3_reg <= full2_reg;
        end
    end

    assign avg      = avg_reg;
    assign full_out = full3_reg;

endmodule
